[hdl/pds_pkg.sv]
package pds_pkg;

   // Widths of the step remainder, quotient, pixel clock, loop divider, best remainder and divider registers
   localparam int REM_W  = 13;
   localparam int K_W    = 9;
   localparam int QP_W   = 4;
   localparam int P_W    = 16;
   localparam int LDF_W  = 12;
   localparam int BEST_W = 16;
   localparam int POST_W = 5;
   localparam int IDX_W  = 2;

   // One reference step is 50 MHz in centi-MHz
   localparam logic [REM_W-1:0]  STEP_CENTI = 13'd5000;
   localparam logic [BEST_W-1:0] START_BEST = 16'd10000;
   localparam logic [4:0]        FIELD_CONST = 5'h15;
   localparam logic [POST_W-1:0] POST_FIRST = 5'd1;
   localparam logic [POST_W-1:0] POST_LAST  = 5'd31;
   localparam logic [IDX_W-1:0]  IDX_LAST   = 2'd3;

   // Legal window: ref 100..1800 MHz gives k 2..36; vco 600..1800 MHz and
   // the loop divider range 8..225 together give ldf 12..36
   localparam logic [K_W-1:0]   K_MIN   = 9'd2;
   localparam logic [K_W-1:0]   K_MAX   = 9'd36;
   localparam logic [LDF_W-1:0] LDF_MIN = 12'd12;
   localparam logic [LDF_W-1:0] LDF_MAX = 12'd36;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_START,
      ST_PAIR,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_REDUCE,
      ACC_START,
      ACC_ADVANCE
   } acc_op_type;

   typedef struct packed {
      acc_op_type      op;
      logic [P_W-1:0]  clock;
   } acc_ctrl_type;

   typedef struct packed {
      logic             reduce_done;
      logic [K_W-1:0]   k;
      logic [REM_W-1:0] r;
   } acc_stat_type;

   typedef struct packed {
      logic              clear;
      logic              enable;
      logic [IDX_W-1:0]  odf_idx;
      logic [POST_W-1:0] post;
   } pick_ctrl_type;

endpackage

[hdl/pds_acc_unit.sv]
module pds_acc_unit (
   input  logic                  clock,
   input  pds_pkg::acc_ctrl_type ctrl,
   output pds_pkg::acc_stat_type stat
);
   import pds_pkg::*;

   logic [P_W-1:0]   rp_ff, rp_in;
   logic [QP_W-1:0]  qp_ff, qp_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [REM_W-1:0] r_ff, r_in;
   logic [P_W-1:0]   add_a;
   logic [P_W-1:0]   add_b;
   logic [P_W-1:0]   sum;
   logic             ge_step;
   logic [P_W-1:0]   wrapped;

   // Shared add and compare against one step
   always_comb begin
      add_a = (ctrl.op == ACC_ADVANCE) ? P_W'(r_ff) : rp_ff;
      add_b = (ctrl.op == ACC_ADVANCE) ? rp_ff : '0;
      sum     = add_a + add_b;
      ge_step = (sum >= P_W'(STEP_CENTI));
      wrapped = sum - P_W'(STEP_CENTI);
   end

   // Select next values per operation
   always_comb begin
      rp_in = rp_ff;
      qp_in = qp_ff;
      k_in  = k_ff;
      r_in  = r_ff;
      case (ctrl.op)
         ACC_LOAD: begin
            rp_in = ctrl.clock;
            qp_in = '0;
         end
         ACC_REDUCE: begin
            if (ge_step) begin
               rp_in = wrapped;
               qp_in = qp_ff + QP_W'(1);
            end
         end
         ACC_START: begin
            k_in = K_W'(qp_ff);
            r_in = rp_ff[REM_W-1:0];
         end
         ACC_ADVANCE: begin
            if (ge_step) begin
               r_in = wrapped[REM_W-1:0];
               k_in = k_ff + K_W'(qp_ff) + K_W'(1);
            end else begin
               r_in = sum[REM_W-1:0];
               k_in = k_ff + K_W'(qp_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rp_ff <= rp_in;
      qp_ff <= qp_in;
      k_ff  <= k_in;
      r_ff  <= r_in;
   end

   assign stat.reduce_done = (rp_ff < P_W'(STEP_CENTI));
   assign stat.k           = k_ff;
   assign stat.r           = r_ff;

endmodule

[hdl/pds_pick.sv]
module pds_pick (
   input  logic                   clock,
   input  pds_pkg::pick_ctrl_type ctrl,
   input  pds_pkg::acc_stat_type  stat,
   output logic [31:0]            word,
   output logic                   found
);
   import pds_pkg::*;

   logic [BEST_W-1:0] best_ff, best_in;
   logic [POST_W-1:0] best_post_ff, best_post_in;
   logic [7:0]        best_ldf_ff, best_ldf_in;
   logic [IDX_W-1:0]  best_code_ff, best_code_in;
   logic              have_ff, have_in;
   logic [LDF_W-1:0]  ldf;
   logic [BEST_W-1:0] rem;
   logic              legal;

   // Scale quotient and remainder by the output divider
   always_comb begin
      ldf   = LDF_W'(stat.k) << ctrl.odf_idx;
      rem   = BEST_W'(stat.r) << ctrl.odf_idx;
      legal = (stat.k >= K_MIN) && (stat.k <= K_MAX) &&
              (ldf >= LDF_MIN) && (ldf <= LDF_MAX);
   end

   // Keep the first pair with the smallest remainder
   always_comb begin
      best_in      = best_ff;
      best_post_in = best_post_ff;
      best_ldf_in  = best_ldf_ff;
      best_code_in = best_code_ff;
      have_in      = have_ff;
      if (ctrl.clear) begin
         best_in = START_BEST;
         have_in = 1'b0;
      end else if (ctrl.enable && legal && (rem < best_ff)) begin
         best_in      = rem;
         best_post_in = ctrl.post;
         best_ldf_in  = ldf[7:0];
         best_code_in = ctrl.odf_idx;
         have_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_post_ff <= best_post_in;
      best_ldf_ff  <= best_ldf_in;
      best_code_ff <= best_code_in;
      have_ff      <= have_in;
   end

   assign found = have_ff;
   assign word  = have_ff ? {3'b000, best_post_ff, best_ldf_ff, 9'd0, best_code_ff, FIELD_CONST}
                          : 32'd0;

endmodule

[hdl/pll_divider_search.sv]
// Channel  Direction  Beat contents
// req      in         tdata[15:0] pixel_clock_centi_mhz
// rsp      out        tdata[31:0] pll_word, tuser[0] found
//
// After a request is accepted, the shared subtractor splits the clock into
// steps of 50 MHz until the remainder is seen to settle below one step; then
// the accumulator is seeded, the divider pairs are scanned one pair a cycle
// through the shared accumulator, and the output register is loaded.
// req_tready is high only when idle.
// A result waits in the output register; a new request is taken meanwhile.
// A search that ends while the previous result still waits holds until it goes.
// reset is synchronous and clears the sequencer and the output valid.
module pll_divider_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] pixel_clock_centi_mhz
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pll_word
   output logic [0:0]  rsp_tuser    // [0] found
);
   import pds_pkg::*;

   state_type         state_ff, state_in;
   logic [POST_W-1:0] post_ff, post_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_word_ff;
   logic              rsp_found_ff;
   logic              req_beat;
   logic              out_free;
   logic              last_pair;
   acc_ctrl_type      acc_ctrl;
   acc_stat_type      acc_stat;
   pick_ctrl_type     pick_ctrl;
   logic [31:0]       pick_word;
   logic              pick_found;

   assign req_beat  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign last_pair = (idx_ff == IDX_LAST) && (post_ff == POST_LAST);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_beat) state_in = ST_REDUCE;
         ST_REDUCE: if (acc_stat.reduce_done) state_in = ST_START;
         ST_START:  state_in = ST_PAIR;
         ST_PAIR:   if (last_pair) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready        = 1'b0;
      acc_ctrl.op       = ACC_HOLD;
      acc_ctrl.clock    = req_tdata;
      pick_ctrl.clear   = 1'b0;
      pick_ctrl.enable  = 1'b0;
      pick_ctrl.odf_idx = idx_ff;
      pick_ctrl.post    = post_ff;
      post_in           = post_ff;
      idx_in            = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            acc_ctrl.op     = ACC_LOAD;
            pick_ctrl.clear = 1'b1;
         end
         ST_REDUCE: begin
            acc_ctrl.op = ACC_REDUCE;
         end
         ST_START: begin
            acc_ctrl.op = ACC_START;
            post_in     = POST_FIRST;
            idx_in      = '0;
         end
         ST_PAIR: begin
            pick_ctrl.enable = 1'b1;
            idx_in           = idx_ff + IDX_W'(1);
            if ((idx_ff == IDX_LAST) && !last_pair) begin
               acc_ctrl.op = ACC_ADVANCE;
               post_in     = post_ff + POST_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == ST_DONE && out_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and result payload
   always_ff @(posedge clock) begin
      post_ff <= post_in;
      idx_ff  <= idx_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_word_ff  <= pick_word;
         rsp_found_ff <= pick_found;
      end
   end

   pds_acc_unit u_acc (
      .clock (clock),
      .ctrl  (acc_ctrl),
      .stat  (acc_stat)
   );

   pds_pick u_pick (
      .clock (clock),
      .ctrl  (pick_ctrl),
      .stat  (acc_stat),
      .word  (pick_word),
      .found (pick_found)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_word_ff;
   assign rsp_tuser[0] = rsp_found_ff;

`ifndef SYNTHESIS
   // Remainder stays below one step while pairs are scanned
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR |-> acc_stat.r < STEP_CENTI)
      else $error("step remainder out of range");

   // Post divider counter stays within its range while scanning
   a_post_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR |-> (post_ff >= POST_FIRST) && (post_ff <= POST_LAST))
      else $error("post divider counter out of range");

   // A result without a legal pair carries a zero word
   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("word not zero without a legal pair");

   // A found word carries the fixed field and a legal loop divider
   a_found_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[4:0] == FIELD_CONST) &&
      (rsp_tdata[23:16] >= LDF_MIN[7:0]) && (rsp_tdata[23:16] <= LDF_MAX[7:0]))
      else $error("found word malformed");

   // Finishing a search presents a result on the next cycle
   a_done_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished search did not present a result");
`endif

endmodule
